// ----- hw/rtl/point_rotate_perspective_top_macros.svh -----
// ----------------------------------------------------------------------------
// Point rotate / perspective assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_PERSPECTIVE_TOP_MACROS_SVH
`define POINT_ROTATE_PERSPECTIVE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PRP_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prp check failed");

// next-cycle implication
`define PRP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prp check failed");

`endif

// ----- hw/rtl/prp_pkg.sv -----
// ----------------------------------------------------------------------------
// Point rotate / perspective package
// Shared types, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

  localparam int CFG_AW   = 5;
  localparam int TRIG_W   = 18;
  localparam int ATAN_LEN = 24;
  localparam int ATAN_IW  = 5;
  localparam int CORDIC_W = 34;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0   = 34'sd652032874;
  localparam logic        [15:0]         FOCAL_RESET = 16'd10000;

  typedef enum logic [2:0] {
    REG_ANGLE_X = 3'd0,
    REG_ANGLE_Y = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_FOCAL   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRG_IDLE,
    TRG_RUN,
    TRG_STORE
  } trg_state_t;

  typedef logic signed [TRIG_W-1:0] trig_val_t;

  typedef struct packed {
    trig_val_t cx;
    trig_val_t sx;
    trig_val_t cy;
    trig_val_t sy;
    trig_val_t cz;
    trig_val_t sz;
  } trig_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prp_trig.sv -----
// ----------------------------------------------------------------------------
// Trig cache
// Iterative CORDIC that refreshes cos/sin of each angle after it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_trig #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     start,
  input  wire logic [15:0]    angle_x,
  input  wire logic [15:0]    angle_y,
  input  wire logic [15:0]    angle_z,
  output prp_pkg::trig_t      trig,
  output logic                busy
);
  import prp_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  trg_state_t state_r, state_nxt;
  logic [2:0] pend_r, pend_nxt, clr;
  logic [1:0] sel_r, sel_nxt, pick;
  logic [1:0] quad_r, quad_nxt;
  logic [ATAN_IW-1:0] step_r, step_nxt;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [CORDIC_W-1:0] dx, dy, at, c_v, s_v;
  logic [15:0] ang;
  trig_t cache_r;

  function automatic trig_val_t to_q16(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W:0] t;
    logic signed [CORDIC_W:0] r;
    t = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(8192);
    r = t >>> 14;
    if (r > (CORDIC_W+1)'(65536)) begin
      r = (CORDIC_W+1)'(65536);
    end else if (r < -(CORDIC_W+1)'(65536)) begin
      r = -(CORDIC_W+1)'(65536);
    end
    return r[TRIG_W-1:0];
  endfunction

  always_comb begin
    if (pend_r[0]) begin
      pick = 2'd0;
    end else if (pend_r[1]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
    case (pick)
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TRG_IDLE: begin
        if (pend_r != 3'b000) state_nxt = TRG_RUN;
      end
      TRG_RUN: begin
        if (step_r == ATAN_IW'(NSTEP - 1)) state_nxt = TRG_STORE;
      end
      TRG_STORE: state_nxt = TRG_IDLE;
      default:   state_nxt = TRG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_r != TRG_IDLE) || (pend_r != 3'b000);
    clr  = 3'b000;
    if (state_r == TRG_IDLE && pend_r != 3'b000) clr = 3'b001 << pick;
  end

  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = $signed({2'b00, atan_turn(step_r)});
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    sel_nxt  = sel_r;
    quad_nxt = quad_r;
    pend_nxt = (pend_r & ~clr) | start;
    case (state_r)
      TRG_IDLE: begin
        if (pend_r != 3'b000) begin
          sel_nxt  = pick;
          quad_nxt = ang[15:14];
          x_nxt    = CORDIC_X0;
          y_nxt    = '0;
          z_nxt    = $signed({4'b0000, ang[13:0], 16'h0000});
          step_nxt = '0;
        end
      end
      TRG_RUN: begin
        if (!z_r[CORDIC_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        step_nxt = step_r + 1'b1;
      end
      default: ;
    endcase
    case (quad_r)
      2'd0: begin
        c_v = x_r;
        s_v = y_r;
      end
      2'd1: begin
        c_v = -y_r;
        s_v = x_r;
      end
      2'd2: begin
        c_v = -x_r;
        s_v = -y_r;
      end
      default: begin
        c_v = y_r;
        s_v = -x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRG_IDLE;
      pend_r  <= 3'b111;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    sel_r  <= sel_nxt;
    quad_r <= quad_nxt;
    if (state_r == TRG_STORE) begin
      case (sel_r)
        2'd0: begin
          cache_r.cx <= to_q16(c_v);
          cache_r.sx <= to_q16(s_v);
        end
        2'd1: begin
          cache_r.cy <= to_q16(c_v);
          cache_r.sy <= to_q16(s_v);
        end
        default: begin
          cache_r.cz <= to_q16(c_v);
          cache_r.sz <= to_q16(s_v);
        end
      endcase
    end
  end

  assign trig = cache_r;

endmodule

`default_nettype wire

// ----- hw/rtl/prp_rot.sv -----
// ----------------------------------------------------------------------------
// Rotation pipeline
// X, then Y, then Z rotation; a multiply stage and an add stage per axis.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_rot #(
  parameter int CW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  input  wire logic signed [CW-1:0] pz,
  input  wire prp_pkg::trig_t       trig,
  output logic                      out_valid,
  output logic signed [CW+5:0]      zx,
  output logic signed [CW+5:0]      zy,
  output logic signed [CW+3:0]      yz
);
  import prp_pkg::*;

  localparam int W1 = CW + 2;
  localparam int W2 = CW + 4;
  localparam int W3 = CW + 6;

  logic [5:0] v_r;

  // x axis
  logic signed [CW+17:0] m_yc, m_zs, m_ys, m_zc;
  logic signed [CW:0]    a_yc_r, a_zs_r, a_ys_r, a_zc_r;
  logic signed [CW-1:0]  x1_r, x2_r;
  logic signed [W1-1:0]  xy2_r, xz2_r, xy3_r, xy4_r;

  // y axis
  logic signed [W1+17:0] m_xzc, m_xzs;
  logic signed [CW+17:0] m_xs, m_xc;
  logic signed [W1:0]    b_xzc_r, b_xs_r, b_xzs_r, b_xc_r;
  logic signed [W2-1:0]  yz4_r, yx4_r, yz5_r, yz6_r;

  // z axis
  logic signed [W2+17:0] m_yxc, m_yxs;
  logic signed [W1+17:0] m_xys, m_xyc;
  logic signed [W2:0]    c_yxc_r, c_xys_r, c_yxs_r, c_xyc_r;
  logic signed [W3-1:0]  zx6_r, zy6_r;

  always_comb begin
    m_yc  = (CW+18)'(py) * (CW+18)'(trig.cx);
    m_zs  = (CW+18)'(pz) * (CW+18)'(trig.sx);
    m_ys  = (CW+18)'(py) * (CW+18)'(trig.sx);
    m_zc  = (CW+18)'(pz) * (CW+18)'(trig.cx);
    m_xzc = (W1+18)'(xz2_r) * (W1+18)'(trig.cy);
    m_xzs = (W1+18)'(xz2_r) * (W1+18)'(trig.sy);
    m_xs  = (CW+18)'(x2_r) * (CW+18)'(trig.sy);
    m_xc  = (CW+18)'(x2_r) * (CW+18)'(trig.cy);
    m_yxc = (W2+18)'(yx4_r) * (W2+18)'(trig.cz);
    m_yxs = (W2+18)'(yx4_r) * (W2+18)'(trig.sz);
    m_xys = (W1+18)'(xy4_r) * (W1+18)'(trig.sz);
    m_xyc = (W1+18)'(xy4_r) * (W1+18)'(trig.cz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_yc_r  <= $signed(m_yc[CW+16:16]);
      a_zs_r  <= $signed(m_zs[CW+16:16]);
      a_ys_r  <= $signed(m_ys[CW+16:16]);
      a_zc_r  <= $signed(m_zc[CW+16:16]);
      x1_r    <= px;

      xy2_r   <= W1'(a_yc_r) - W1'(a_zs_r);
      xz2_r   <= W1'(a_ys_r) + W1'(a_zc_r);
      x2_r    <= x1_r;

      b_xzc_r <= $signed(m_xzc[W1+16:16]);
      b_xzs_r <= $signed(m_xzs[W1+16:16]);
      b_xs_r  <= (W1+1)'($signed(m_xs[CW+16:16]));
      b_xc_r  <= (W1+1)'($signed(m_xc[CW+16:16]));
      xy3_r   <= xy2_r;

      yz4_r   <= W2'(b_xzc_r) - W2'(b_xs_r);
      yx4_r   <= W2'(b_xzs_r) + W2'(b_xc_r);
      xy4_r   <= xy3_r;

      c_yxc_r <= $signed(m_yxc[W2+16:16]);
      c_yxs_r <= $signed(m_yxs[W2+16:16]);
      c_xys_r <= (W2+1)'($signed(m_xys[W1+16:16]));
      c_xyc_r <= (W2+1)'($signed(m_xyc[W1+16:16]));
      yz5_r   <= yz4_r;

      zx6_r   <= W3'(c_yxc_r) - W3'(c_xys_r);
      zy6_r   <= W3'(c_yxs_r) + W3'(c_xyc_r);
      yz6_r   <= yz5_r;
    end
  end

  assign out_valid = v_r[5];
  assign zx        = zx6_r;
  assign zy        = zy6_r;
  assign yz        = yz6_r;

endmodule

`default_nettype wire

// ----- hw/rtl/prp_div.sv -----
// ----------------------------------------------------------------------------
// Projection divider
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_div #(
  parameter int DW   = 70,
  parameter int DN_W = 37,
  parameter int SW   = 38
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [DW-1:0]   nx,
  input  wire logic [DW-1:0]   ny,
  input  wire logic [DN_W-1:0] d,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic [DW-1:0]        qx,
  output logic [DW-1:0]        qy,
  output logic [SW-1:0]        side_out
);

  logic            v_r    [DW];
  logic [DW-1:0]   nx_r   [DW];
  logic [DW-1:0]   ny_r   [DW];
  logic [DN_W-1:0] rx_r   [DW];
  logic [DN_W-1:0] ry_r   [DW];
  logic [DN_W-1:0] d_r    [DW];
  logic [SW-1:0]   side_r [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stg
    logic            cv;
    logic [DW-1:0]   cnx, cny;
    logic [DN_W-1:0] crx, cry, cd;
    logic [SW-1:0]   cside;
    logic [DN_W:0]   tx, ty;
    logic            gx, gy;

    if (i == 0) begin : g_first
      always_comb begin
        cv    = in_valid;
        cnx   = nx;
        cny   = ny;
        crx   = '0;
        cry   = '0;
        cd    = d;
        cside = side_in;
      end
    end else begin : g_next
      always_comb begin
        cv    = v_r[i-1];
        cnx   = nx_r[i-1];
        cny   = ny_r[i-1];
        crx   = rx_r[i-1];
        cry   = ry_r[i-1];
        cd    = d_r[i-1];
        cside = side_r[i-1];
      end
    end

    always_comb begin
      tx = {crx, cnx[DW-1]};
      ty = {cry, cny[DW-1]};
      gx = tx >= {1'b0, cd};
      gy = ty >= {1'b0, cd};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[i]   <= gx ? DN_W'(tx - {1'b0, cd}) : tx[DN_W-1:0];
        ry_r[i]   <= gy ? DN_W'(ty - {1'b0, cd}) : ty[DN_W-1:0];
        nx_r[i]   <= {cnx[DW-2:0], gx};
        ny_r[i]   <= {cny[DW-2:0], gy};
        d_r[i]    <= cd;
        side_r[i] <= cside;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign qx        = nx_r[DW-1];
  assign qy        = ny_r[DW-1];
  assign side_out  = side_r[DW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/point_rotate_perspective_top.sv -----
// ----------------------------------------------------------------------------
// Point rotate / perspective top
// Rotates each Q16.16 point about X, Y and Z, scales x and y by
// focal/(focal + depth), adds the shifts and saturates. Takes one word per
// clock while in_ready is high, through the six rotation stages and the
// one-bit-per-stage projection divider behind them.
// After reset, and after each angle write, in_ready stays low while the
// CORDIC refreshes that angle's cos/sin; after reset all three angles run
// back to back. A zero projection denominator sets out_divide_fault and
// drives out_x/out_y to the extreme of their sign, or to zero where the
// rotated value is zero. Registers sit at byte address 4*index.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_perspective_top #(
  parameter int COORD_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic                               out_divide_fault,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [prp_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import prp_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int W2    = CW + 4;
  localparam int W3    = CW + 6;
  localparam int DEN_W = ((W2 > 33) ? W2 : 33) + 1;
  localparam int ZW    = ((W2 > 32) ? W2 : 32) + 1;
  localparam int DW    = W3 + 32;
  localparam int SW    = CW + 6;
  localparam int OW    = 3 * CW + 1;

  // configuration
  logic [15:0]        angle_x_r, angle_y_r, angle_z_r, focal_r;
  logic signed [31:0] shift_x_r, shift_y_r, shift_z_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [2:0]         trig_start;
  trig_t              trig;
  logic               trig_busy;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_comb begin
    trig_start = 3'b000;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_ANGLE_X: trig_start = 3'b001;
        REG_ANGLE_Y: trig_start = 3'b010;
        REG_ANGLE_Z: trig_start = 3'b100;
        default:     trig_start = 3'b000;
      endcase
    end
    case (cfg_idx)
      REG_ANGLE_X: prdata = {16'h0000, angle_x_r};
      REG_ANGLE_Y: prdata = {16'h0000, angle_y_r};
      REG_ANGLE_Z: prdata = {16'h0000, angle_z_r};
      REG_FOCAL:   prdata = {16'h0000, focal_r};
      REG_SHIFT_X: prdata = shift_x_r;
      REG_SHIFT_Y: prdata = shift_y_r;
      REG_SHIFT_Z: prdata = shift_z_r;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
      focal_r   <= FOCAL_RESET;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ANGLE_X: angle_x_r <= pwdata[15:0];
        REG_ANGLE_Y: angle_y_r <= pwdata[15:0];
        REG_ANGLE_Z: angle_z_r <= pwdata[15:0];
        REG_FOCAL:   focal_r   <= pwdata[15:0];
        REG_SHIFT_X: shift_x_r <= pwdata;
        REG_SHIFT_Y: shift_y_r <= pwdata;
        REG_SHIFT_Z: shift_z_r <= pwdata;
        default: ;
      endcase
    end
  end

  prp_trig #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (trig_start),
    .angle_x (angle_x_r),
    .angle_y (angle_y_r),
    .angle_z (angle_z_r),
    .trig    (trig),
    .busy    (trig_busy)
  );

  // pipeline control: everything advances unless the skid word is held
  logic skid_v_r, out_v_r, en, in_acc;

  assign en       = !skid_v_r;
  assign in_ready = en && !trig_busy;
  assign in_acc   = in_valid && in_ready;

  logic                 rot_v;
  logic signed [W3-1:0] rot_zx, rot_zy;
  logic signed [W2-1:0] rot_yz;

  prp_rot #(
    .CW (CW)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_acc),
    .px        (in_point_x),
    .py        (in_point_y),
    .pz        (in_point_z),
    .trig      (trig),
    .out_valid (rot_v),
    .zx        (rot_zx),
    .zy        (rot_zy),
    .yz        (rot_yz)
  );

  // denominator, magnitudes, depth output
  logic signed [DEN_W-1:0] den_c, den1_r;
  logic signed [ZW-1:0]    zsum;
  logic [CW-1:0]           oz_c, oz1_r, oz2_r;
  logic [W3-1:0]           magx1_r, magy1_r;
  logic                    v1_r, v2_r;
  logic                    xs1_r, xnz1_r, ys1_r, ynz1_r;
  logic                    xs2_r, xnz2_r, ys2_r, ynz2_r;

  always_comb begin
    den_c = $signed({{(DEN_W-32){1'b0}}, focal_r, 16'h0000}) + DEN_W'(rot_yz);
    zsum  = ZW'(rot_yz) + ZW'(shift_z_r);
    if (&zsum[ZW-1:CW-1] || ~|zsum[ZW-1:CW-1]) begin
      oz_c = zsum[CW-1:0];
    end else begin
      oz_c = {zsum[ZW-1], {(CW-1){~zsum[ZW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= rot_v;
      v2_r <= v1_r;
    end
  end

  logic [DW-1:0]    nx2_r, ny2_r;
  logic [DEN_W-1:0] d2_r;
  logic             fault2_r, dneg2_r;
  logic [W3+15:0]   prodx, prody;

  always_comb begin
    prodx = (W3+16)'(magx1_r) * (W3+16)'(focal_r);
    prody = (W3+16)'(magy1_r) * (W3+16)'(focal_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den1_r   <= den_c;
      oz1_r    <= oz_c;
      magx1_r  <= rot_zx[W3-1] ? W3'(-rot_zx) : W3'(rot_zx);
      magy1_r  <= rot_zy[W3-1] ? W3'(-rot_zy) : W3'(rot_zy);
      xs1_r    <= rot_zx[W3-1];
      xnz1_r   <= |rot_zx;
      ys1_r    <= rot_zy[W3-1];
      ynz1_r   <= |rot_zy;

      nx2_r    <= {prodx, 16'h0000};
      ny2_r    <= {prody, 16'h0000};
      d2_r     <= den1_r[DEN_W-1] ? DEN_W'(-den1_r) : DEN_W'(den1_r);
      fault2_r <= ~|den1_r;
      dneg2_r  <= den1_r[DEN_W-1];
      oz2_r    <= oz1_r;
      xs2_r    <= xs1_r;
      xnz2_r   <= xnz1_r;
      ys2_r    <= ys1_r;
      ynz2_r   <= ynz1_r;
    end
  end

  logic          dv_v;
  logic [DW-1:0] qx, qy;
  logic [SW-1:0] side_out;

  prp_div #(
    .DW   (DW),
    .DN_W (DEN_W),
    .SW   (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .nx        (nx2_r),
    .ny        (ny2_r),
    .d         (d2_r),
    .side_in   ({oz2_r, fault2_r, dneg2_r, xs2_r, xnz2_r, ys2_r, ynz2_r}),
    .out_valid (dv_v),
    .qx        (qx),
    .qy        (qy),
    .side_out  (side_out)
  );

  // final shift, saturation and fault override
  logic                 f_fault, f_dneg, f_xs, f_xnz, f_ys, f_ynz;
  logic [CW-1:0]        f_oz, f_ox, f_oy;
  logic signed [DW:0]   sqx, sqy;
  logic signed [DW+1:0] sumx, sumy;
  logic [CW-1:0]        pos_max, neg_max;

  always_comb begin
    {f_oz, f_fault, f_dneg, f_xs, f_xnz, f_ys, f_ynz} = side_out;
    pos_max = {1'b0, {(CW-1){1'b1}}};
    neg_max = {1'b1, {(CW-1){1'b0}}};
    sqx  = (f_xs ^ f_dneg) ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    sqy  = (f_ys ^ f_dneg) ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    sumx = (DW+2)'(sqx) + (DW+2)'(shift_x_r);
    sumy = (DW+2)'(sqy) + (DW+2)'(shift_y_r);
    if (f_fault) begin
      f_ox = !f_xnz ? '0 : (f_xs ? neg_max : pos_max);
      f_oy = !f_ynz ? '0 : (f_ys ? neg_max : pos_max);
    end else begin
      if (&sumx[DW+1:CW-1] || ~|sumx[DW+1:CW-1]) begin
        f_ox = sumx[CW-1:0];
      end else begin
        f_ox = sumx[DW+1] ? neg_max : pos_max;
      end
      if (&sumy[DW+1:CW-1] || ~|sumy[DW+1:CW-1]) begin
        f_oy = sumy[CW-1:0];
      end else begin
        f_oy = sumy[DW+1] ? neg_max : pos_max;
      end
    end
  end

  // output register with skid word
  logic [OW-1:0] out_d_r, skid_d_r, res_c;
  logic          take;

  assign res_c = {f_ox, f_oy, f_oz, f_fault};
  assign take  = dv_v && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || take;
      skid_v_r <= 1'b0;
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_d_r <= skid_v_r ? skid_d_r : res_c;
    end else if (take) begin
      skid_d_r <= res_c;
    end
  end

  assign out_valid        = out_v_r;
  assign out_x            = out_d_r[3*CW:2*CW+1];
  assign out_y            = out_d_r[2*CW:CW+1];
  assign out_z            = out_d_r[CW:1];
  assign out_divide_fault = out_d_r[0];

endmodule

`default_nettype wire

// ----- hw/rtl/prp_checker.sv -----
// ----------------------------------------------------------------------------
// Point rotate / perspective port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_rotate_perspective_top_macros.svh"

module prp_checker #(
  parameter int CW = 32
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [CW-1:0]              out_x,
  input wire logic                       out_divide_fault,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [prp_pkg::CFG_AW-1:0] paddr,
  input wire logic                       pready
);
  import prp_pkg::*;

  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_MAX = {1'b1, {(CW-1){1'b0}}};

  logic ang_wr;

  assign ang_wr = psel && penable && pwrite &&
                  (paddr[CFG_AW-1:2] inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z});

  `PRP_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x))
  `PRP_NOW(a_pready_high, 1'b1, pready)
  `PRP_NEXT(a_angle_stall, ang_wr, !in_ready)
  `PRP_NOW(a_fault_extreme, out_valid && out_divide_fault, out_x == POS_MAX || out_x == NEG_MAX || out_x == '0)

endmodule

bind point_rotate_perspective_top prp_checker #(
  .CW (COORD_WIDTH)
) u_prp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_x            (out_x),
  .out_divide_fault (out_divide_fault),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .paddr            (paddr),
  .pready           (pready)
);

`default_nettype wire
